FILE: sv/ctcgd_pkg.sv
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared types and constants of the CTC greedy decoder: result kinds, the
// divider status word and the exp(-d/256) lookup table in Q0.16.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  // Result kinds carried on the output word.
  localparam logic [1:0] KIND_SYMBOL  = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // Exp table geometry: entry d is exp(-d/256) in Q0.16, zero beyond the end.
  localparam int EXP_LEN = 4096;
  localparam int EXP_IW  = 12;
  localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;

  // Q0.16 one, the numerator of the step probability is its square.
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef logic [16:0] exp_rom_t [EXP_LEN];

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Builds the table from a rounded Q0.32 recurrence of exp(-1/256).
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [64:0] t;
    t = 65'h1_0000_0000;
    for (int d = 0; d < EXP_LEN; d++) begin
      if (d > 0) begin
        t = ((t * 65'(EXP_STEP_Q32)) + 65'h8000_0000) >> 32;
      end
      rom[d] = 17'((t + 65'd32768) >> 16);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: sv/ctcgd_ram.sv
// ----------------------------------------------------------------------------
// ctcgd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ctcgd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/ctcgd_div.sv
// ----------------------------------------------------------------------------
// ctcgd_div
// Shared restoring divider. Produces one quotient bit per cycle while busy;
// done pulses for one cycle and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module ctcgd_div #(
  parameter int NW = 33,
  parameter int VW = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NW-1:0]             dividend,
  input  logic [VW-1:0]             divisor,
  output ctcgd_pkg::div_status_t    status,
  output logic [NW-1:0]             quotient
);

  import ctcgd_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [VW-1:0] rem;
  logic [NW-1:0] num;
  logic [VW-1:0] dvsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [VW:0]   trial;
  logic          fits;

  // One trial subtraction per cycle.
  assign trial = {rem, num[NW-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      num  <= '0;
      dvsr <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= dividend;
        dvsr <= divisor;
        rem  <= '0;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? VW'(trial - {1'b0, dvsr}) : trial[VW-1:0];
        num <= {num[NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = num;

endmodule

FILE: sv/ctc_greedy_decoder.sv
// ----------------------------------------------------------------------------
// ctc_greedy_decoder
// CTC greedy best-path decoder: buffers each row of class logits, finds the
// argmax, computes the step probability 1 / sum(exp(score - max)) and emits
// non-blank, non-repeated classes, then a mean-confidence summary per sequence.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Word
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_stall  score, last_step
//  out      out_valid/out_stall  kind, class_index, confidence,
//                                symbol_count, done_res
//  cfg      cfg_valid/cfg_ready  cfg_index (0 class_count, 1 blank_class),
//                                cfg_data
//
//  Scores that do not end their row are taken back to back. A row end runs an
//  exp-sum pass over its n scores, a divider run (NW = 33 quotient bits), a
//  decision and, for an emitted symbol, the load of the symbol word; a last row
//  adds the mean division when there is something to average and the load of
//  the summary. Reset clears control state, not the row buffer. in_stall is
//  high until scores are taken again, longer while out_stall holds a word.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder #(
  parameter int MAX_CLASSES = 128,
  parameter int MAX_SYMBOLS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] score,
  input  logic               last_step,
  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [6:0]         class_index,
  output logic [16:0]        confidence,
  output logic [12:0]        symbol_count,
  output logic               done_res,
  // Configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);

  import ctcgd_pkg::*;

  localparam int PW   = $clog2(MAX_CLASSES);
  localparam int LW   = (PW + 1 > 8) ? PW + 1 : 8;
  localparam int BW   = (PW > 7) ? PW : 7;
  localparam int SW   = $clog2(MAX_SYMBOLS + 1);
  localparam int CTW  = 17 + SW;
  localparam int SUMW = 17 + PW;
  localparam int NW   = (CTW > 33) ? CTW : 33;
  localparam int VW   = (SUMW > SW) ? SUMW : SW;

  localparam logic [0:0] REG_CLASS_COUNT = 1'b0;
  localparam logic [0:0] REG_BLANK_CLASS = 1'b1;

  typedef enum logic [6:0] {
    S_IN     = 7'b0000001,
    S_SUM    = 7'b0000010,
    S_PDIV   = 7'b0000100,
    S_SYM    = 7'b0001000,
    S_MEAN   = 7'b0010000,
    S_MDIV   = 7'b0100000,
    S_SUMOUT = 7'b1000000
  } state_t;

  state_t            state;
  logic [7:0]        class_count;
  logic [6:0]        blank_class;
  logic [PW-1:0]     position;
  logic signed [15:0] best_score;
  logic [PW-1:0]     best_class;
  logic [PW-1:0]     last_pos;
  logic [PW-1:0]     prev_class;
  logic              prev_valid;
  logic [CTW-1:0]    conf_total;
  logic [SW-1:0]     symbols;
  logic              last_flag;
  logic              row_invalid;
  logic [PW-1:0]     rd_addr;
  logic              rd_issued;
  logic              v1;
  logic              v2;
  logic [16:0]       exp_q;
  logic [SUMW-1:0]   sum;
  logic [16:0]       conf_val;

  logic              in_accept;
  logic [LW-1:0]     row_len;
  logic              row_end;
  logic              take_best;
  logic              cfg_invalid;
  logic signed [15:0] ram_q;
  logic signed [16:0] diff;
  logic              out_free;
  logic              out_load;
  logic              emit_now;
  logic [16:0]       prob;
  logic              div_start;
  logic [NW-1:0]     div_dividend;
  logic [VW-1:0]     div_divisor;
  div_status_t       div_st;
  logic [NW-1:0]     div_quot;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= 8'd2;
      blank_class <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLASS_COUNT: class_count <= cfg_data;
        REG_BLANK_CLASS: blank_class <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Row length clamped into 2..MAX_CLASSES, and the configuration check.
  always_comb begin
    if (class_count < 8'd2) begin
      row_len = LW'(2);
    end else if (LW'(class_count) > LW'(MAX_CLASSES)) begin
      row_len = LW'(MAX_CLASSES);
    end else begin
      row_len = LW'(class_count);
    end
  end

  assign cfg_invalid = (class_count < 8'd2) ||
                       (LW'(class_count) > LW'(MAX_CLASSES)) ||
                       ({1'b0, blank_class} >= class_count);

  assign in_stall  = (state != S_IN);
  assign in_accept = in_valid && !in_stall;
  assign row_end   = (LW'(position) + LW'(1)) >= row_len;
  assign take_best = (position == '0) || (score > best_score);

  // Row buffer: written on accept, read once per cycle in the sum pass.
  ctcgd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CLASSES)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (position),
    .wr_data (score),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Distance from the row maximum; never negative for the entries the sum pass adds.
  assign diff = {best_score[15], best_score} - {ram_q[15], ram_q};

  // Exp table lookup, registered.
  always_ff @(posedge clk) begin
    if (diff[16:EXP_IW] != '0) begin
      exp_q <= '0;
    end else begin
      exp_q <= EXP_ROM[diff[EXP_IW-1:0]];
    end
  end

  // Shared divider: probability at the end of a row, mean at the sequence end.
  assign div_start = ((state == S_SUM) && rd_issued && !v1 && !v2) ||
                     ((state == S_MEAN) && !row_invalid && (symbols != '0));

  always_comb begin
    if (state == S_MEAN) begin
      div_dividend = NW'(conf_total);
      div_divisor  = VW'(symbols);
    end else begin
      div_dividend = NW'(ONE_Q32);
      div_divisor  = VW'(sum);
    end
  end

  ctcgd_div #(
    .NW (NW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st),
    .quotient (div_quot)
  );

  assign prob     = div_quot[16:0];
  assign emit_now = !row_invalid &&
                    (BW'(best_class) != BW'(blank_class)) &&
                    !(prev_valid && (best_class == prev_class));
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == S_SYM) || (state == S_SUMOUT)) && out_free;

  // Output valid: set when a word is loaded, cleared when it leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IN;
      position     <= '0;
      best_score   <= '0;
      best_class   <= '0;
      last_pos     <= '0;
      prev_class   <= '0;
      prev_valid   <= 1'b0;
      conf_total   <= '0;
      symbols      <= '0;
      last_flag    <= 1'b0;
      row_invalid  <= 1'b0;
      rd_addr      <= '0;
      rd_issued    <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      sum          <= '0;
      conf_val     <= '0;
      kind         <= KIND_SYMBOL;
      class_index  <= '0;
      confidence   <= '0;
      symbol_count <= '0;
      done_res     <= 1'b0;
    end else begin
      unique case (state)
        // Take scores, track the running argmax, detect the row end.
        S_IN: begin
          if (in_accept) begin
            if (take_best) begin
              best_score <= score;
              best_class <= position;
            end
            if (row_end) begin
              position    <= '0;
              last_pos    <= position;
              last_flag   <= last_step;
              row_invalid <= cfg_invalid;
              rd_addr     <= '0;
              rd_issued   <= 1'b0;
              v1          <= 1'b0;
              v2          <= 1'b0;
              sum         <= '0;
              state       <= S_SUM;
            end else begin
              position <= position + 1'b1;
            end
          end
        end

        // Re-read the row and accumulate the exp terms.
        S_SUM: begin
          v1 <= !rd_issued;
          v2 <= v1;
          if (!rd_issued) begin
            if (rd_addr == last_pos) begin
              rd_issued <= 1'b1;
            end else begin
              rd_addr <= rd_addr + 1'b1;
            end
          end
          if (v2) begin
            sum <= sum + SUMW'(exp_q);
          end
          if (rd_issued && !v1 && !v2) begin
            state <= S_PDIV;
          end
        end

        // Probability ready: decide on a symbol and update the totals.
        S_PDIV: begin
          if (div_st.done) begin
            conf_val   <= prob;
            prev_class <= best_class;
            prev_valid <= 1'b1;
            if (emit_now && (symbols < SW'(MAX_SYMBOLS))) begin
              symbols    <= symbols + 1'b1;
              conf_total <= conf_total + CTW'(prob);
            end
            if (emit_now) begin
              state <= S_SYM;
            end else if (last_flag) begin
              state <= S_MEAN;
            end else begin
              state <= S_IN;
            end
          end
        end

        // Load the symbol word once the output register is free.
        S_SYM: begin
          if (out_free) begin
            kind         <= KIND_SYMBOL;
            class_index  <= 7'(best_class);
            confidence   <= conf_val;
            symbol_count <= 13'(symbols);
            done_res     <= 1'b0;
            state        <= last_flag ? S_MEAN : S_IN;
          end
        end

        // Start the mean division, or skip it if invalid or there is nothing to average.
        S_MEAN: begin
          if (div_start) begin
            state <= S_MDIV;
          end else begin
            conf_val <= '0;
            state    <= S_SUMOUT;
          end
        end

        S_MDIV: begin
          if (div_st.done) begin
            conf_val <= div_quot[16:0];
            state    <= S_SUMOUT;
          end
        end

        // Load the summary word and clear the sequence state.
        S_SUMOUT: begin
          if (out_free) begin
            kind         <= row_invalid ? KIND_INVALID : KIND_SUMMARY;
            class_index  <= '0;
            confidence   <= row_invalid ? 17'd0 : conf_val;
            symbol_count <= row_invalid ? 13'd0 : 13'(symbols);
            done_res     <= 1'b1;
            prev_valid   <= 1'b0;
            prev_class   <= '0;
            conf_total   <= '0;
            symbols      <= '0;
            state        <= S_IN;
          end
        end

        default: state <= S_IN;
      endcase
    end
  end

  // The symbol counter saturates at its limit.
  a_symbols_bound: assert property (@(posedge clk) disable iff (rst)
    symbols <= SW'(MAX_SYMBOLS))
    else $error("symbol counter above its limit");

  // Each counted symbol adds at most one in Q0.16 to the total.
  a_conf_bound: assert property (@(posedge clk) disable iff (rst)
    CTW'(conf_total) <= {symbols, 16'd0})
    else $error("confidence total exceeds symbol count");

  // The divider is never restarted while a division is running.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // A row end always leaves the write position at the row start.
  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && row_end) |=> (position == '0))
    else $error("row position not cleared at row end");

endmodule

FILE: tb/ctc_greedy_checker.sv
// ----------------------------------------------------------------------------
// ctc_greedy_checker
// Watches the score, result and register channels of the CTC greedy decoder,
// predicts every decoded word from its own model of the row argmax, the
// exp-sum probability and the per-sequence mean, and compares field by field.
// ----------------------------------------------------------------------------
module ctc_greedy_checker #(
  parameter int   MAX_CLASSES     = 128,
  parameter int   MAX_SYMBOLS     = 4096,
  parameter logic REG_CLASS_COUNT = 1'b0,
  parameter logic REG_BLANK_CLASS = 1'b1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] score,
  input  logic               last_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         kind,
  input  logic [6:0]         class_index,
  input  logic [16:0]        confidence,
  input  logic [12:0]        symbol_count,
  input  logic               done_res,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               wrap_up,
  output int                 pending,
  output int                 failures
);
  timeunit 1ns;
  timeprecision 1ps;

  import ctcgd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  cls;
    logic [16:0] conf;
    logic [12:0] count;
    logic        done;
  } decoded_word_t;

  // Words the decoder still owes, oldest first.
  decoded_word_t decode_q[$];

  logic [16:0]        exp_lut [EXP_LEN];
  logic [7:0]         n_classes;
  logic [6:0]         blank_idx;
  logic signed [15:0] row_buf [MAX_CLASSES];
  logic signed [15:0] peak_score;
  int                 col;
  int                 peak_class;
  int                 last_class;
  bit                 last_class_ok;
  longint unsigned    conf_acc;
  int                 sym_cnt;
  int                 fail_total = 0;
  bit                 wrapped = 0;

  assign failures = fail_total;

  // The exp(-d/256) table in Q0.16, from a rounded Q0.32 recurrence.
  initial begin
    logic [95:0] t;
    t = 96'd1 << 32;
    for (int d = 0; d < EXP_LEN; d++) begin
      if (d > 0) begin
        t = (t * 96'(EXP_STEP_Q32) + (96'd1 << 31)) >> 32;
      end
      exp_lut[d] = 17'((t + 96'd32768) >> 16);
    end
  end

  // One score in; at a row end, the symbol and summary words it causes.
  task automatic decode_score(input logic signed [15:0] s, input logic lst);
    int              row_len;
    int              n;
    int              d;
    longint unsigned lut_sum;
    longint unsigned prob;
    longint unsigned mean;
    bit              bad;
    decoded_word_t   w;
    row_len = (n_classes < 2) ? 2 : ((n_classes > MAX_CLASSES) ? MAX_CLASSES : n_classes);
    if (col >= MAX_CLASSES) begin
      col = 0;
    end
    row_buf[col] = s;
    if (col == 0 || s > peak_score) begin
      peak_score = s;
      peak_class = col;
    end
    if (col + 1 < row_len) begin
      col++;
      return;
    end
    n   = col + 1;
    col = 0;

    // Sum of exp(score - max) over the row; far-off scores contribute nothing.
    lut_sum = 0;
    for (int i = 0; i < n; i++) begin
      d = int'(peak_score) - int'(row_buf[i]);
      if (d < EXP_LEN) begin
        lut_sum += exp_lut[d];
      end
    end
    prob = (lut_sum != 0) ? (64'd1 << 32) / lut_sum : 64'd0;

    bad = (n_classes < 2) || (n_classes > MAX_CLASSES) || (blank_idx >= n_classes);
    if (!bad && peak_class != blank_idx && !(last_class_ok && peak_class == last_class)) begin
      // Once the symbol counter saturates, the total stops moving too.
      if (sym_cnt < MAX_SYMBOLS) begin
        sym_cnt++;
        conf_acc += prob;
      end
      w.kind  = KIND_SYMBOL;
      w.cls   = 7'(peak_class);
      w.conf  = 17'(prob);
      w.count = 13'(sym_cnt);
      w.done  = 1'b0;
      decode_q = {decode_q, w};
    end
    last_class    = peak_class;
    last_class_ok = 1'b1;

    // The last row closes the sequence with a summary word.
    if (lst) begin
      if (bad) begin
        w.kind  = KIND_INVALID;
        w.conf  = '0;
        w.count = '0;
      end else begin
        mean    = (sym_cnt != 0) ? conf_acc / longint'(sym_cnt) : 64'd0;
        w.kind  = KIND_SUMMARY;
        w.conf  = 17'(mean);
        w.count = 13'(sym_cnt);
      end
      w.cls  = '0;
      w.done = 1'b1;
      decode_q = {decode_q, w};
      last_class_ok = 1'b0;
      last_class    = 0;
      conf_acc      = 0;
      sym_cnt       = 0;
    end
  endtask

  // Compares a delivered word with the oldest one owed.
  task automatic check_word();
    decoded_word_t want;
    if (decode_q.size() == 0) begin
      $error("unexpected output word: kind %0d class %0d", kind, class_index);
      fail_total++;
      return;
    end
    want = decode_q.pop_front();
    if (kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, kind);
      fail_total++;
    end
    if (class_index !== want.cls) begin
      $error("class_index: expected %0d, got %0d", want.cls, class_index);
      fail_total++;
    end
    if (confidence !== want.conf) begin
      $error("confidence: expected %0d, got %0d", want.conf, confidence);
      fail_total++;
    end
    if (symbol_count !== want.count) begin
      $error("symbol_count: expected %0d, got %0d", want.count, symbol_count);
      fail_total++;
    end
    if (done_res !== want.done) begin
      $error("done_res: expected %0d, got %0d", want.done, done_res);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decode_q.delete();
      n_classes     = 8'd2;
      blank_idx     = 7'd0;
      col           = 0;
      peak_score    = '0;
      peak_class    = 0;
      last_class    = 0;
      last_class_ok = 1'b0;
      conf_acc      = 0;
      sym_cnt       = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_word();
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CLASS_COUNT) begin
          n_classes = cfg_data;
        end else if (cfg_index == REG_BLANK_CLASS) begin
          blank_idx = cfg_data[6:0];
        end
      end
      if (in_valid && !in_stall) begin
        decode_score(score, last_step);
      end
      // At the end of the run, anything still owed is a failure.
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (decode_q.size() != 0) begin
          $error("%0d decoded words never arrived", decode_q.size());
          fail_total += decode_q.size();
        end
      end
    end
    pending <= decode_q.size();
  end

endmodule

FILE: tb/tb_ctc_greedy_decoder.sv
// ----------------------------------------------------------------------------
// tb_ctc_greedy_decoder
// Drives rows of class scores into the CTC greedy decoder under several
// register settings, with bursty input and a patterned output stall, and
// lets the checker judge every decoded word.
// ----------------------------------------------------------------------------
module tb_ctc_greedy_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   MAX_CLASSES     = 128;
  localparam int   MAX_SYMBOLS     = 4096;
  localparam logic REG_CLASS_COUNT = 1'b0;
  localparam logic REG_BLANK_CLASS = 1'b1;
  localparam int   SETTLE_CYCLES   = 250;
  localparam int   HOLD_CYCLES     = 400;
  localparam int   NUM_PHASES      = 9;

  // Register settings of the random part, with a rough word budget each.
  localparam int PHASE_CC    [NUM_PHASES] = '{2, 3, 5, 128, 1, 255, 16, 7, 2};
  localparam int PHASE_BC    [NUM_PHASES] = '{1, 0, 2, 127, 0, 5, 16, 6, 0};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{20, 18, 10, 1, 8, 1, 1, 14, 10};

  // Ties, the edge of the exp table and a repeated argmax, four classes.
  localparam logic signed [15:0] TIE_ROWS [16] = '{
    16'sd5,  16'sd5, 16'sd5, 16'sd5,
    -16'sd1, 16'sd0, 16'sd0, -16'sd4095,
    -16'sd1, 16'sd0, 16'sd0, -16'sd4096,
    16'sd7,  16'sd6, 16'sd6, 16'sh8000
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] score;
  logic               last_step;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         kind;
  logic [6:0]         class_index;
  logic [16:0]        confidence;
  logic [12:0]        symbol_count;
  logic               done_res;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [7:0]         cfg_data;
  logic               wrap_up;
  logic               hold_off;
  int                 pending;
  int                 failures;
  int                 burst_left;

  ctc_greedy_decoder #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .score        (score),
    .last_step    (last_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .class_index  (class_index),
    .confidence   (confidence),
    .symbol_count (symbol_count),
    .done_res     (done_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ctc_greedy_checker #(
    .MAX_CLASSES     (MAX_CLASSES),
    .MAX_SYMBOLS     (MAX_SYMBOLS),
    .REG_CLASS_COUNT (REG_CLASS_COUNT),
    .REG_BLANK_CLASS (REG_BLANK_CLASS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .score        (score),
    .last_step    (last_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .class_index  (class_index),
    .confidence   (confidence),
    .symbol_count (symbol_count),
    .done_res     (done_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .wrap_up      (wrap_up),
    .pending      (pending),
    .failures     (failures)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the decoder hangs.
  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  // Output stall: one long hold-off on request, otherwise a changing pattern.
  initial begin
    int         mode;
    int         left;
    int         hold_cnt;
    bit         held;
    logic [7:0] pat;
    mode      = 0;
    left      = 0;
    hold_cnt  = 0;
    held      = 1'b0;
    pat       = 8'b1011_0010;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held     = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: begin
            pat = {pat[6:0], pat[7]};
            out_stall <= pat[0];
          end
        endcase
      end
    end
  end

  // Offers one score word and waits until it is taken; gaps come between bursts.
  task automatic send_score(input logic signed [15:0] s, input logic lst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid  <= 1'b1;
    score     <= s;
    last_step <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Lets every owed word arrive, then lets the decoder settle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Both registers; the unused top bit of the blank write is random.
  task automatic write_regs(input logic [7:0] cc, input logic [6:0] bc);
    settle();
    write_reg(REG_CLASS_COUNT, cc);
    @(posedge clk);
    write_reg(REG_BLANK_CLASS, {1'($urandom_range(0, 1)), bc});
  endtask

  initial begin
    int   rows;
    int   row_len;
    int   sent;
    int   mode;
    int   top;
    int   w;
    int   v;
    logic lst;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    score      <= '0;
    last_step  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_CLASS_COUNT;
    cfg_data   <= '0;
    wrap_up    <= 1'b0;
    hold_off   <= 1'b0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: the extremes of the score, blank winning, then a symbol.
    send_score(16'sh7fff, 1'b0);
    send_score(16'sh8000, 1'b0);
    send_score(16'sh8000, 1'b1);
    send_score(16'sh7fff, 1'b1);

    write_regs(8'd4, 7'd3);
    for (int i = 0; i < 16; i++) begin
      send_score(TIE_ROWS[i], i == 15);
    end

    // Row length lowered in the middle of a row; the row then ends early,
    // and the blank index is out of range, so the summary flags it.
    write_regs(8'd8, 7'd3);
    send_score(16'sd100, 1'b0);
    send_score(16'sd200, 1'b1);
    send_score(-16'sd300, 1'b0);
    settle();
    write_reg(REG_CLASS_COUNT, 8'd2);
    send_score(16'sd50, 1'b1);

    // A class count of zero is invalid and runs as two classes.
    write_regs(8'd0, 7'd0);
    send_score(16'sd3, 1'b0);
    send_score(16'sd3, 1'b1);

    // Random sequences under each setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_regs(8'(PHASE_CC[p]), 7'(PHASE_BC[p]));
      if (p == 0) begin
        hold_off <= 1'b1;
      end
      row_len = (PHASE_CC[p] < 2) ? 2 : ((PHASE_CC[p] > MAX_CLASSES) ? MAX_CLASSES : PHASE_CC[p]);
      sent    = 0;
      while (sent < PHASE_ITEMS[p]) begin
        rows = (row_len > 16) ? 1 : $urandom_range(1, 6);
        for (int r = 0; r < rows; r++) begin
          // Row shapes: spread anywhere, near the table edge, near ties, one winner.
          mode = $urandom_range(0, 3);
          top  = $urandom_range(0, 65535) - 32768;
          w    = $urandom_range(0, row_len - 1);
          for (int c = 0; c < row_len; c++) begin
            case (mode)
              0: v = $urandom_range(0, 65535) - 32768;
              1: v = top - $urandom_range(0, 4200);
              2: v = top - $urandom_range(0, 3);
              default: v = (c == w) ? top : top - $urandom_range(1, 3000);
            endcase
            if (v < -32768) begin
              v = -32768;
            end
            lst = (r == rows - 1 && c == row_len - 1) ? 1'b1 : 1'($urandom_range(0, 1));
            send_score(16'(v), lst);
            sent++;
          end
        end
      end
    end

    settle();
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
